// ----- src/pdd_pkg.sv -----
package pdd_pkg;

  localparam int CFG_W   = 24;
  localparam int COUNT_W = 8;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HEADER_NOM = 3'd0;
  localparam logic [2:0] REG_HEADER_TOL = 3'd1;
  localparam logic [2:0] REG_SHORT_NOM  = 3'd2;
  localparam logic [2:0] REG_LONG_NOM   = 3'd3;
  localparam logic [2:0] REG_ELEM_TOL   = 3'd4;
  localparam logic [2:0] REG_END_GAP    = 3'd5;
  localparam logic [2:0] REG_MIN_BITS   = 3'd6;

  localparam logic [CFG_W-1:0]   RST_HEADER_NOM = 24'd35000;
  localparam logic [CFG_W-1:0]   RST_HEADER_TOL = 24'd105000;
  localparam logic [CFG_W-1:0]   RST_SHORT_NOM  = 24'd1000;
  localparam logic [CFG_W-1:0]   RST_LONG_NOM   = 24'd2000;
  localparam logic [CFG_W-1:0]   RST_ELEM_TOL   = 24'd3000;
  localparam logic [CFG_W-1:0]   RST_END_GAP    = 24'd4000;
  localparam logic [COUNT_W-1:0] RST_MIN_BITS   = 8'd36;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // classified-item queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0]   header_nominal;
    logic [CFG_W-1:0]   header_tolerance;
    logic [CFG_W-1:0]   short_nominal;
    logic [CFG_W-1:0]   long_nominal;
    logic [CFG_W-1:0]   element_tolerance;
    logic [CFG_W-1:0]   end_gap;
    logic [COUNT_W-1:0] min_bits;
  } cfg_t;

  // one interval after classification
  typedef struct packed {
    logic level;
    logic near_header;
    logic near_short;
    logic near_long;
    logic past_end;
  } class_t;

endpackage

// ----- src/pdd_regs.sv -----
module pdd_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pdd_pkg::cfg_t cfg
);
  import pdd_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_nominal    <= RST_HEADER_NOM;
      cfg_r.header_tolerance  <= RST_HEADER_TOL;
      cfg_r.short_nominal     <= RST_SHORT_NOM;
      cfg_r.long_nominal      <= RST_LONG_NOM;
      cfg_r.element_tolerance <= RST_ELEM_TOL;
      cfg_r.end_gap           <= RST_END_GAP;
      cfg_r.min_bits          <= RST_MIN_BITS;
    end else if (wr_en) begin
      case (idx)
        REG_HEADER_NOM: cfg_r.header_nominal    <= pwdata[CFG_W-1:0];
        REG_HEADER_TOL: cfg_r.header_tolerance  <= pwdata[CFG_W-1:0];
        REG_SHORT_NOM:  cfg_r.short_nominal     <= pwdata[CFG_W-1:0];
        REG_LONG_NOM:   cfg_r.long_nominal      <= pwdata[CFG_W-1:0];
        REG_ELEM_TOL:   cfg_r.element_tolerance <= pwdata[CFG_W-1:0];
        REG_END_GAP:    cfg_r.end_gap           <= pwdata[CFG_W-1:0];
        REG_MIN_BITS:   cfg_r.min_bits          <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER_NOM: prdata = 32'(cfg_r.header_nominal);
      REG_HEADER_TOL: prdata = 32'(cfg_r.header_tolerance);
      REG_SHORT_NOM:  prdata = 32'(cfg_r.short_nominal);
      REG_LONG_NOM:   prdata = 32'(cfg_r.long_nominal);
      REG_ELEM_TOL:   prdata = 32'(cfg_r.element_tolerance);
      REG_END_GAP:    prdata = 32'(cfg_r.end_gap);
      REG_MIN_BITS:   prdata = 32'(cfg_r.min_bits);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/pdd_front.sv -----
module pdd_front #(
  parameter int DURATION_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pdd_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_level,
  input  logic [DURATION_WIDTH-1:0] in_duration,
  output logic                      q_valid,
  output pdd_pkg::class_t           q_head,
  output logic [DURATION_WIDTH-1:0] q_dur,
  input  logic                      q_pop
);
  import pdd_pkg::*;

  localparam int CW = (DURATION_WIDTH > CFG_W) ? DURATION_WIDTH : CFG_W;

  function automatic logic near(input logic [CW-1:0] d, input logic [CW-1:0] nom,
                                input logic [CW-1:0] tol);
    logic [CW-1:0] diff;
    diff = (d > nom) ? (d - nom) : (nom - d);
    return diff < tol;
  endfunction

  logic [CW-1:0] dur;
  class_t        cls;
  logic          wr;

  class_t                    mem_r [QDEPTH];
  logic [DURATION_WIDTH-1:0] dur_mem_r [QDEPTH];
  logic [QPTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]         count_r, count_nxt;

  assign dur = CW'(in_duration);

  always_comb begin
    cls.level       = in_level;
    cls.near_header = near(dur, CW'(cfg.header_nominal), CW'(cfg.header_tolerance));
    cls.near_short  = near(dur, CW'(cfg.short_nominal), CW'(cfg.element_tolerance));
    cls.near_long   = near(dur, CW'(cfg.long_nominal), CW'(cfg.element_tolerance));
    cls.past_end    = dur >= CW'(cfg.end_gap);
  end

  assign in_ready = count_r != QCNT_W'(QDEPTH);
  assign wr       = in_valid && in_ready;
  assign q_valid  = count_r != '0;
  assign q_head   = mem_r[rd_ptr_r];
  assign q_dur    = dur_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr && !q_pop)      count_nxt = count_r + 1'b1;
    else if (!wr && q_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r]     <= cls;
      dur_mem_r[wr_ptr_r] <= in_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr)    wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !q_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a transfer");
`endif

endmodule

// ----- src/pdd_back.sv -----
module pdd_back #(
  parameter int DATA_WIDTH     = 64,
  parameter int DURATION_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdd_pkg::cfg_t               cfg,
  input  logic                        q_valid,
  input  pdd_pkg::class_t             q_head,
  input  logic [DURATION_WIDTH-1:0]   q_dur,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DATA_WIDTH-1:0]       out_frame_bits,
  output logic [pdd_pkg::COUNT_W-1:0] out_bit_count
);
  import pdd_pkg::*;

  localparam int CW = (DURATION_WIDTH > CFG_W) ? DURATION_WIDTH : CFG_W;

  function automatic logic near(input logic [CW-1:0] d, input logic [CW-1:0] nom,
                                input logic [CW-1:0] tol);
    logic [CW-1:0] diff;
    diff = (d > nom) ? (d - nom) : (nom - d);
    return diff < tol;
  endfunction

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_START  = 4'b0010,
    PH_SAVE   = 4'b0100,
    PH_CHECK  = 4'b1000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DURATION_WIDTH-1:0] saved_gap_r;
  logic                gap_short, gap_long;
  logic [DATA_WIDTH-1:0] shift_r, shift_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                emit_req, out_free;
  logic                out_valid_r;
  logic [DATA_WIDTH-1:0] out_bits_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [COUNT_W-1:0]  count_inc;

  assign emit_req = (phase_r == PH_SAVE) && !q_head.level && q_head.past_end &&
                    (count_r >= cfg.min_bits);
  assign out_free = !out_valid_r || out_ready;
  // items that end no frame keep flowing while a result waits
  assign q_pop    = q_valid && (!emit_req || out_free);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  // held gap is judged against the registers as they are when its pulse arrives
  assign gap_short = near(CW'(saved_gap_r), CW'(cfg.short_nominal),
                          CW'(cfg.element_tolerance));
  assign gap_long  = near(CW'(saved_gap_r), CW'(cfg.long_nominal),
                          CW'(cfg.element_tolerance));

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    case (phase_r)
      PH_HEADER: begin
        if (!q_head.level && q_head.near_header) phase_nxt = PH_START;
      end
      PH_START: begin
        if (q_head.level) begin
          if (q_head.near_short) begin
            phase_nxt = PH_SAVE;
            shift_nxt = '0;
            count_nxt = '0;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_SAVE: begin
        if (q_head.level)         phase_nxt = PH_HEADER;
        else if (q_head.past_end) phase_nxt = PH_START;
        else                      phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (!q_head.level) begin
          phase_nxt = PH_HEADER;
        end else if (gap_short && q_head.near_long) begin
          shift_nxt = {shift_r[DATA_WIDTH-2:0], 1'b1};
          count_nxt = count_inc;
          phase_nxt = PH_SAVE;
        end else if (gap_long && q_head.near_short) begin
          shift_nxt = {shift_r[DATA_WIDTH-2:0], 1'b0};
          count_nxt = count_inc;
          phase_nxt = PH_SAVE;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      shift_r     <= '0;
      count_r     <= '0;
      saved_gap_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      if (phase_r == PH_SAVE && !q_head.level && !q_head.past_end) begin
        saved_gap_r <= q_dur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && emit_req) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit_req) begin
      out_bits_r  <= shift_r;
      out_count_r <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_bits = out_bits_r;
  assign out_bit_count  = out_count_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(q_pop && emit_req))
    else $error("pending result overwritten");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && phase_r == PH_START && q_head.level && q_head.near_short)
      |=> (count_r == '0 && phase_r == PH_SAVE))
    else $error("frame start did not clear the bit count");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready)
      |=> (out_valid_r && $stable(out_bits_r) && $stable(out_count_r)))
    else $error("result changed while waiting");
`endif

endmodule

// ----- src/pulse_distance_decoder_core.sv -----
// Pulse-distance frame decoder.
// Input channel: one interval per transfer, in_level (1 high pulse, 0 low gap)
// and in_duration in microseconds. A front stage compares the duration with
// the configured nominal values and writes the result into a four-entry queue;
// a back stage runs the header / start / gap / pulse state machine from the
// queue and assembles bits.
// Output channel: one transfer per reported frame, out_frame_bits holds the
// newest DATA_WIDTH bits (newest in bit 0), out_bit_count the bit count
// saturated at 255. A frame is reported when a low gap at or above end_gap
// follows a pulse of the frame and at least min_bits bits were collected.
// Throughput: one interval per cycle while the queue is not full.
// With the queue empty, the gap that ends the frame is written into the queue
// at its transfer, then the state update loads the output register and raises
// out_valid; entries already queued ahead of it are handled first.
// If the receiver stalls, the result register holds; intervals that end no
// frame keep draining, and input stalls only once the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result,
// returns the decoder to waiting for a header and restores register defaults.
// Registers sit on the APB port at byte address 4*index; pready is always high.
module pulse_distance_decoder_core #(
  parameter int DATA_WIDTH     = 64,
  parameter int DURATION_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_level,
  input  logic [DURATION_WIDTH-1:0]   in_duration,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DATA_WIDTH-1:0]       out_frame_bits,
  output logic [pdd_pkg::COUNT_W-1:0] out_bit_count
);
  import pdd_pkg::*;

  cfg_t   cfg;
  logic   q_valid, q_pop;
  class_t q_head;
  logic [DURATION_WIDTH-1:0] q_dur;

  pdd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdd_front #(.DURATION_WIDTH(DURATION_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_level    (in_level),
    .in_duration (in_duration),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_dur       (q_dur),
    .q_pop       (q_pop)
  );

  pdd_back #(
    .DATA_WIDTH     (DATA_WIDTH),
    .DURATION_WIDTH (DURATION_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_dur          (q_dur),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_bits (out_frame_bits),
    .out_bit_count  (out_bit_count)
  );

endmodule

// ----- bench/pulse_distance_decoder_core_tb.sv -----
module pulse_distance_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdd_pkg::*;

  localparam int DATA_W         = 64;
  localparam int DUR_W          = 24;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  // {level, duration}; walks every decoder phase and its corner cases
  localparam logic [24:0] DIRECTED_ITEMS [22] = '{
    {1'b1, 24'hFFFFFF}, {1'b0, 24'd0},    {1'b0, 24'd5000}, {1'b0, 24'hFFFFFF},
    {1'b1, 24'd500},    {1'b0, 24'd1000}, {1'b1, 24'd1000}, {1'b0, 24'd1500},
    {1'b1, 24'd500},    {1'b0, 24'd3000}, {1'b1, 24'd500},  {1'b0, 24'd500},
    {1'b1, 24'd1500},   {1'b0, 24'd3000}, {1'b1, 24'd500},  {1'b1, 24'd100},
    {1'b0, 24'd5000},   {1'b1, 24'd500},  {1'b0, 24'd500},  {1'b0, 24'd500},
    {1'b0, 24'd4001},   {1'b1, 24'd1100}
  };

  typedef enum logic [1:0] {
    AWAIT_HEADER,
    AWAIT_START,
    SAVE_GAP,
    CHECK_PULSE
  } decode_phase_t;

  typedef struct packed {
    logic [DATA_W-1:0]  bits;
    logic [COUNT_W-1:0] count;
  } frame_t;

  class decoder_scoreboard;
    frame_t             frames_due[$];
    logic [CFG_W-1:0]   hdr_nom, hdr_tol, short_nom, long_nom, elem_tol, end_gap;
    logic [COUNT_W-1:0] min_bits;
    decode_phase_t      phase;
    logic [DUR_W-1:0]   held_gap;
    logic [DATA_W-1:0]  shift_reg;
    logic [COUNT_W-1:0] bit_cnt;
    int                 errors;

    function new();
      hdr_nom   = RST_HEADER_NOM;
      hdr_tol   = RST_HEADER_TOL;
      short_nom = RST_SHORT_NOM;
      long_nom  = RST_LONG_NOM;
      elem_tol  = RST_ELEM_TOL;
      end_gap   = RST_END_GAP;
      min_bits  = RST_MIN_BITS;
      phase     = AWAIT_HEADER;
      held_gap  = '0;
      shift_reg = '0;
      bit_cnt   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_HEADER_NOM: hdr_nom   = val[CFG_W-1:0];
        REG_HEADER_TOL: hdr_tol   = val[CFG_W-1:0];
        REG_SHORT_NOM:  short_nom = val[CFG_W-1:0];
        REG_LONG_NOM:   long_nom  = val[CFG_W-1:0];
        REG_ELEM_TOL:   elem_tol  = val[CFG_W-1:0];
        REG_END_GAP:    end_gap   = val[CFG_W-1:0];
        REG_MIN_BITS:   min_bits  = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // strict window: |d - nom| < tol
    function bit in_window(logic [DUR_W-1:0] d, logic [CFG_W-1:0] nom,
                           logic [CFG_W-1:0] tol);
      logic [CFG_W-1:0] diff;
      diff = (d > nom) ? d - nom : nom - d;
      return diff < tol;
    endfunction

    function void shift_in(logic b);
      shift_reg = {shift_reg[DATA_W-2:0], b};
      if (bit_cnt != COUNT_MAX) bit_cnt++;
    endfunction

    function void note_input(logic level, logic [DUR_W-1:0] dur);
      frame_t f;
      case (phase)
        AWAIT_HEADER: begin
          if (!level && in_window(dur, hdr_nom, hdr_tol)) phase = AWAIT_START;
        end
        AWAIT_START: begin
          // low gaps are ignored here
          if (level) begin
            if (in_window(dur, short_nom, elem_tol)) begin
              phase     = SAVE_GAP;
              shift_reg = '0;
              bit_cnt   = '0;
            end else begin
              phase = AWAIT_HEADER;
            end
          end
        end
        SAVE_GAP: begin
          if (level) begin
            phase = AWAIT_HEADER;
          end else if (dur >= end_gap) begin
            phase = AWAIT_START;
            if (bit_cnt >= min_bits) begin
              f.bits  = shift_reg;
              f.count = bit_cnt;
              frames_due.push_back(f);
            end
          end else begin
            held_gap = dur;
            phase    = CHECK_PULSE;
          end
        end
        default: begin
          // the one test wins when both windows match
          if (!level) begin
            phase = AWAIT_HEADER;
          end else if (in_window(held_gap, short_nom, elem_tol) &&
                       in_window(dur, long_nom, elem_tol)) begin
            shift_in(1'b1);
            phase = SAVE_GAP;
          end else if (in_window(held_gap, long_nom, elem_tol) &&
                       in_window(dur, short_nom, elem_tol)) begin
            shift_in(1'b0);
            phase = SAVE_GAP;
          end else begin
            phase = AWAIT_HEADER;
          end
        end
      endcase
    endfunction

    function void check_result(logic [DATA_W-1:0] bits, logic [COUNT_W-1:0] cnt);
      frame_t exp_frame;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: frame_bits %h bit_count %0d", bits, cnt);
        errors++;
        return;
      end
      exp_frame = frames_due.pop_front();
      if (bits !== exp_frame.bits) begin
        $error("frame_bits mismatch: expected %h, actual %h", exp_frame.bits, bits);
        errors++;
      end
      if (cnt !== exp_frame.count) begin
        $error("bit_count mismatch: expected %0d, actual %0d", exp_frame.count, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_level = 1'b0;
  logic [DUR_W-1:0]   in_duration = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  out_frame_bits;
  logic [COUNT_W-1:0] out_bit_count;

  decoder_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int stall_cycles   = 0;

  pulse_distance_decoder_core #(
    .DATA_WIDTH     (DATA_W),
    .DURATION_WIDTH (DUR_W)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_level       (in_level),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_bits (out_frame_bits),
    .out_bit_count  (out_bit_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_frame_bits, out_bit_count);
      if (in_valid && in_ready) sb.note_input(in_level, in_duration);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // duration inside the window around nom; with allow_miss a few land just outside
  function automatic logic [DUR_W-1:0] near_value(logic [CFG_W-1:0] nom,
                                                 logic [CFG_W-1:0] tol, bit allow_miss);
    longint n, t, v;
    int     sel;
    n   = nom;
    t   = tol;
    sel = $urandom_range(0, 199);
    if (t == 0) begin
      v = n;
    end else if (sel < 5) begin
      v = n + t - 1;
    end else if (sel < 10) begin
      v = n - (t - 1);
    end else if (allow_miss && sel == 10) begin
      v = n + t;
    end else if (allow_miss && sel == 11) begin
      v = n - t;
    end else begin
      v = n + longint'($urandom_range(0, 2 * (t - 1))) - (t - 1);
    end
    // keep in-window values below all-ones so a full-scale end gap stays distinct
    if (v < 0) v = 0;
    if (v > DUR_MAX - 1) v = DUR_MAX - 1;
    return v[DUR_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] end_value();
    longint v;
    v = sb.end_gap;
    if ($urandom_range(0, 1)) v += $urandom_range(1, 5000);
    if (v > DUR_MAX) v = DUR_MAX;
    return v[DUR_W-1:0];
  endfunction

  task automatic send_item(input logic lvl, input logic [DUR_W-1:0] dur);
    case ((items_sent / 40) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_level    <= lvl;
    in_duration <= dur;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(1'($urandom_range(0, 1)), DUR_W'($urandom_range(0, DUR_MAX)));
  endtask

  task automatic send_frame(input int nbits, input bit clean);
    bit b;
    send_item(1'b0, near_value(sb.hdr_nom, sb.hdr_tol, !clean));
    send_item(1'b1, near_value(sb.short_nom, sb.elem_tol, !clean));
    for (int i = 0; i < nbits; i++) begin
      if (!clean && $urandom_range(0, 49) == 0) send_noise();
      if (!clean && $urandom_range(0, 99) == 0) return;  // truncated frame
      b = 1'($urandom_range(0, 1));
      if (b) begin
        send_item(1'b0, near_value(sb.short_nom, sb.elem_tol, !clean));
        send_item(1'b1, near_value(sb.long_nom, sb.elem_tol, !clean));
      end else begin
        send_item(1'b0, near_value(sb.long_nom, sb.elem_tol, !clean));
        send_item(1'b1, near_value(sb.short_nom, sb.elem_tol, !clean));
      end
    end
    send_item(1'b0, end_value());
  endtask

  task automatic run_frames(input int count, input int min_len, input int max_len);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_frame($urandom_range(min_len, max_len), $urandom_range(0, 4) != 0);
    end
  endtask

  // no transfer in flight and nothing owed, then let the queue drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] hn, input logic [CFG_W-1:0] ht,
                              input logic [CFG_W-1:0] sn, input logic [CFG_W-1:0] ln,
                              input logic [CFG_W-1:0] et, input logic [CFG_W-1:0] eg,
                              input logic [COUNT_W-1:0] mb);
    settle();
    write_reg(REG_HEADER_NOM, 32'(hn));
    write_reg(REG_HEADER_TOL, 32'(ht));
    write_reg(REG_SHORT_NOM, 32'(sn));
    write_reg(REG_LONG_NOM, 32'(ln));
    write_reg(REG_ELEM_TOL, 32'(et));
    write_reg(REG_END_GAP, 32'(eg));
    write_reg(REG_MIN_BITS, 32'(mb));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // overlapping short/long windows so one gap/pulse pair matches both
    program_regs(24'd5000, 24'd1000, 24'd500, 24'd1500, 24'd600, 24'd3000, 8'd2);
    foreach (DIRECTED_ITEMS[i]) send_item(DIRECTED_ITEMS[i][24], DIRECTED_ITEMS[i][23:0]);

    program_regs(24'd35000, 24'd105000, 24'd1000, 24'd2000, 24'd3000, 24'd4000, 8'd8);
    run_frames(6, 6, 12);

    // disjoint windows, one frame past the 64-bit shift register
    program_regs(24'd20000, 24'd2000, 24'd400, 24'd1200, 24'd300, 24'd2500, 8'd12);
    run_frames(5, 10, 20);
    send_frame(70, 1'b1);

    // full-scale values; long frame saturates the bit count
    program_regs(DUR_MAX, DUR_MAX, 24'd0, DUR_MAX, 24'h800000, DUR_MAX, COUNT_MAX);
    send_frame(260, 1'b1);

    // every low gap ends the frame, empty frames are reported
    program_regs(24'd0, 24'd1, 24'd0, 24'd1, 24'd1, 24'd0, 8'd0);
    run_frames(25, 0, 2);

    // zero tolerance: nothing ever matches
    program_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 8'd0);
    repeat (30) send_noise();

    program_regs(RST_HEADER_NOM, RST_HEADER_TOL, RST_SHORT_NOM, RST_LONG_NOM,
                 RST_ELEM_TOL, RST_END_GAP, RST_MIN_BITS);
    run_frames(2, 36, 40);
    run_frames(3, 20, 30);

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pdd_pkg.sv
src/pdd_regs.sv
src/pdd_front.sv
src/pdd_back.sv
src/pulse_distance_decoder_core.sv
bench/pulse_distance_decoder_core_tb.sv
